@@ rtl/core/pba_pkg.sv @@
// Package for the paged block allocator: sizes, codes, request/result types.
// No dependencies.
`timescale 1ns / 1ps
package pba_pkg;
  localparam int POOL_SIZE = 1024;
  localparam int MAX_SEQS = 64;
  localparam int MAX_BLOCKS_PER_SEQ = 64;
  localparam int BID_W = 10;
  localparam int CNT_W = 11;
  localparam int LEN_W = 7;
  localparam int SLOT_W = 6;
  localparam int ENT_AW = 12;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_GROW = 3'd1;
  localparam logic [2:0] REQ_APPEND = 3'd2;
  localparam logic [2:0] REQ_FREE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;
  localparam logic [2:0] REQ_QUERY = 3'd5;
  localparam logic [2:0] REQ_INIT = 3'd6;
  // unused code, handled as a query
  localparam logic [2:0] REQ_RSVD = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_OOM = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_BADIDX = 3'd5;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_WMARK = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] seq_slot;
    logic [6:0] block_count;
    logic [6:0] logical_cnt;
    logic [5:0] entry_index;
  } pba_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  blk_id;
    logic        appended;
    logic        can_allocate;
    logic        is_allocated;
    logic [10:0] free_count;
    logic [6:0]  table_length;
  } pba_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_FILL_RD, S_FILL_WR, S_FREE_RD, S_FREE_WR, S_READ, S_DONE
  } pba_state_t;
endpackage

@@ rtl/core/pba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/paged_block_allocator.sv @@
// Paged block allocator top level: free stack RAM, block table RAM, sequencer.
// Depends on pba_pkg and pba_ram.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_stall take one request (pba_in_t); out_valid/out_stall return
//   one result (pba_out_t) per request. One request is in flight at a time;
//   in_stall is high from acceptance until the cycle after the result is taken.
//   cfg_valid/cfg_ready write total_blocks (index 0) or watermark_blocks (1);
//   cfg_ready is always high.
// Steps from acceptance to out_valid:
//   query, errors, no-op paths: dispatch only
//   read_entry: one table RAM read
//   alloc/grow/append: per block moved, read stack then write table
//   free: per table entry, read table then write stack
//   init_pool: total_blocks (capped at the pool size), one stack entry written per cycle
// The moves run one block id at a time through the RAM ports, a read state then a write state.
// Reset empties the free stack and releases all slots; no clearing pass is
// needed since the RAMs are only read below counts that reset zeroes or for
// slots that reset marks free.
// While out_stall is high the result holds and no new request is taken.
module paged_block_allocator
  import pba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pba_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pba_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [10:0] cfg_data
);
  pba_state_t state_r, state_nxt;
  pba_in_t req_r, req_nxt;
  logic [10:0] total_r, wmark_r;
  logic [10:0] top_r, top_nxt;
  logic [MAX_SEQS-1:0] valid_r, valid_nxt;
  logic [LEN_W-1:0] len_wr, cur_len;
  logic [SLOT_W-1:0] len_raddr;
  logic len_we;
  logic [10:0] cnt_r, cnt_nxt;  // remaining moves / init index
  logic [LEN_W-1:0] pos_r, pos_nxt;  // table position
  logic [2:0] st_r, st_nxt;
  logic [9:0] bid_r, bid_nxt;
  logic app_r, app_nxt;
  logic outv_r, outv_nxt;

  logic fs_we;
  logic [BID_W-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  logic te_we;
  logic [ENT_AW-1:0] te_waddr, te_raddr;
  logic [BID_W-1:0] te_wdata, te_rdata;

  pba_ram #(.WIDTH(BID_W), .DEPTH(POOL_SIZE)) u_stack (
    .clk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata));
  pba_ram #(.WIDTH(BID_W), .DEPTH(MAX_SEQS * MAX_BLOCKS_PER_SEQ)) u_table (
    .clk, .we(te_we), .waddr(te_waddr), .wdata(te_wdata),
    .raddr(te_raddr), .rdata(te_rdata));
  // table lengths: read only for valid slots, so no reset needed
  pba_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEQS)) u_len (
    .clk, .we(len_we), .waddr(req_r.seq_slot), .wdata(len_wr),
    .raddr(len_raddr), .rdata(cur_len));

  // look up the incoming slot while idle so the length is ready at dispatch
  assign len_raddr = (state_r == S_IDLE) ? in_data.seq_slot : req_r.seq_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
      valid_r <= '0;
      total_r <= CNT_W'(POOL_SIZE);
      wmark_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      valid_r <= valid_nxt;
      outv_r  <= outv_nxt;
      if (cfg_valid && cfg_index == CFG_TOTAL) total_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_WMARK) wmark_r <= cfg_data;
    end
    req_r <= req_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    bid_r <= bid_nxt;
    app_r <= app_nxt;
  end

  logic [6:0] cnt_in;
  logic [10:0] ntot;
  assign cnt_in = req_r.block_count;
  assign ntot = (total_r > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : total_r;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    top_nxt = top_r;
    valid_nxt = valid_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    st_nxt = st_r;
    bid_nxt = bid_r;
    app_nxt = app_r;
    outv_nxt = outv_r;
    len_we = 1'b0;
    len_wr = cur_len;
    fs_we = 1'b0;
    fs_waddr = top_r[BID_W-1:0];
    fs_wdata = '0;
    fs_raddr = top_r[BID_W-1:0] - 1'b1;
    te_we = 1'b0;
    te_waddr = {req_r.seq_slot, pos_r[5:0]};
    te_wdata = fs_rdata;
    te_raddr = {req_r.seq_slot, pos_r[5:0]};
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.req_type == REQ_RSVD) req_nxt.req_type = REQ_QUERY;
          st_nxt = ST_OK; bid_nxt = '0; app_nxt = 1'b0;
          state_nxt = S_DONE;
          // decide in DONE-less dispatch state below via S_READ reuse
          state_nxt = S_READ;
          pos_nxt = '0;
          cnt_nxt = '0;
        end
      end
      S_READ: begin
        // dispatch: S_READ is entered only from S_IDLE, once per request
        state_nxt = S_DONE;
        case (req_r.req_type)
          REQ_ALLOC, REQ_GROW: begin
            if (valid_r[req_r.seq_slot] && req_r.req_type == REQ_ALLOC) st_nxt = ST_DUP;
            else if (!valid_r[req_r.seq_slot]) begin
              if (cnt_in > LEN_W'(MAX_BLOCKS_PER_SEQ)) st_nxt = ST_FULL;
              else if ({4'd0, cnt_in} > top_r) st_nxt = ST_OOM;
              else begin
                valid_nxt[req_r.seq_slot] = 1'b1;
                len_we = 1'b1; len_wr = '0;
                pos_nxt = '0; cnt_nxt = {4'd0, cnt_in};
                state_nxt = (cnt_in == 7'd0) ? S_DONE : S_FILL_RD;
              end
            end else if (cnt_in > cur_len) begin
              if (cnt_in > LEN_W'(MAX_BLOCKS_PER_SEQ)) st_nxt = ST_FULL;
              else if ({4'd0, cnt_in - cur_len} > top_r) st_nxt = ST_OOM;
              else begin
                pos_nxt = cur_len; cnt_nxt = {4'd0, cnt_in - cur_len};
                state_nxt = S_FILL_RD;
              end
            end
          end
          REQ_APPEND: begin
            if (!valid_r[req_r.seq_slot]) st_nxt = ST_NOTFOUND;
            else if (cnt_in < req_r.logical_cnt) begin
              if (cur_len >= LEN_W'(MAX_BLOCKS_PER_SEQ)) st_nxt = ST_FULL;
              else if (top_r == '0) st_nxt = ST_OOM;
              else begin
                pos_nxt = cur_len; cnt_nxt = 11'd1; app_nxt = 1'b1;
                state_nxt = S_FILL_RD;
              end
            end
          end
          REQ_FREE: begin
            if (valid_r[req_r.seq_slot]) begin
              valid_nxt[req_r.seq_slot] = 1'b0;
              cnt_nxt = {4'd0, cur_len}; pos_nxt = '0;
              state_nxt = (cur_len == '0) ? S_DONE : S_FREE_RD;
            end
          end
          REQ_READ: begin
            if (!valid_r[req_r.seq_slot]) st_nxt = ST_NOTFOUND;
            else if ({1'b0, req_r.entry_index} >= cur_len) st_nxt = ST_BADIDX;
            else begin
              te_raddr = {req_r.seq_slot, req_r.entry_index};
              state_nxt = S_FREE_WR;  // registered table read, captured in S_FREE_WR
              cnt_nxt = '0;
            end
          end
          REQ_INIT: begin
            valid_nxt = '0;
            top_nxt = '0; cnt_nxt = '0;
            state_nxt = (ntot == '0) ? S_DONE : S_INIT;
          end
          default: ;
        endcase
      end
      S_INIT: begin
        fs_we = 1'b1;
        fs_waddr = cnt_r[BID_W-1:0];
        fs_wdata = cnt_r[BID_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        top_nxt = cnt_r + 1'b1;
        if (cnt_r + 1'b1 == ntot) state_nxt = S_DONE;
      end
      S_FILL_RD: begin
        fs_raddr = top_r[BID_W-1:0] - 1'b1;
        top_nxt = top_r - 1'b1;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        te_we = 1'b1;
        te_wdata = fs_rdata;
        len_we = 1'b1; len_wr = pos_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (app_r) bid_nxt = fs_rdata;
        state_nxt = (cnt_r == 11'd1) ? S_DONE : S_FILL_RD;
      end
      S_FREE_RD: begin
        te_raddr = {req_r.seq_slot, pos_r[5:0]};
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        if (req_r.req_type == REQ_READ) begin
          bid_nxt = te_rdata;
          state_nxt = S_DONE;
        end else begin
          if (top_r < CNT_W'(POOL_SIZE)) begin
            fs_we = 1'b1;
            fs_wdata = te_rdata;
            top_nxt = top_r + 1'b1;
          end
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = (cnt_r == 11'd1) ? S_DONE : S_FREE_RD;
        end
      end
      S_DONE: begin
        outv_nxt = 1'b1;
        if (outv_r && !out_stall) begin
          outv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [11:0] need;
  assign need = {5'd0, req_r.block_count} + {1'b0, wmark_r};
  always_comb begin
    out_data.status = st_r;
    out_data.blk_id = bid_r;
    out_data.appended = app_r;
    out_data.can_allocate = ({1'b0, top_r} >= need);
    out_data.is_allocated = valid_r[req_r.seq_slot];
    out_data.free_count = top_r;
    out_data.table_length = valid_r[req_r.seq_slot] ? cur_len : '0;
  end
  assign out_valid = outv_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_top: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CNT_W'(POOL_SIZE)) else $error("free stack overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken with result pending");
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for paged_block_allocator: directed and random requests,
// predicted results compared on the result channel. Depends on pba_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import pba_pkg::*;

  class alloc_scoreboard;
    logic [9:0] stack_ids[POOL_SIZE];
    int         stack_top;
    bit         held[MAX_SEQS];
    int         tbl_len[MAX_SEQS];
    logic [9:0] tbl_ids[MAX_SEQS][MAX_BLOCKS_PER_SEQ];
    int         total_cfg;
    int         wmark_cfg;
    pba_out_t   pending[$];
    int         errors;
    int         results;
    int         ooms;
    int         appends;

    function new();
      stack_top = 0;
      total_cfg = 1024;
      wmark_cfg = 0;
      errors = 0;
      results = 0;
      ooms = 0;
      appends = 0;
      foreach (held[i]) begin
        held[i] = 0;
        tbl_len[i] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [10:0] val);
      if (idx == CFG_TOTAL) total_cfg = val;
      else wmark_cfg = val;
    endfunction

    function void move_to_table(int s, int n);
      for (int i = 0; i < n; i++) begin
        stack_top--;
        tbl_ids[s][tbl_len[s]] = stack_ids[stack_top];
        tbl_len[s]++;
      end
    endfunction

    function logic [2:0] take_new(int s, int n);
      if (n > MAX_BLOCKS_PER_SEQ) return ST_FULL;
      if (n > stack_top) return ST_OOM;
      held[s] = 1;
      tbl_len[s] = 0;
      move_to_table(s, n);
      return ST_OK;
    endfunction

    function void note(pba_in_t r);
      int s, cnt, n;
      logic [2:0] req;
      pba_out_t o;
      s = r.seq_slot;
      cnt = r.block_count;
      req = r.req_type;
      o = '0;
      o.status = ST_OK;
      case (req)
        REQ_ALLOC: o.status = held[s] ? ST_DUP : take_new(s, cnt);
        REQ_GROW: begin
          if (!held[s]) o.status = take_new(s, cnt);
          else if (cnt > tbl_len[s]) begin
            n = cnt - tbl_len[s];
            if (cnt > MAX_BLOCKS_PER_SEQ) o.status = ST_FULL;
            else if (n > stack_top) o.status = ST_OOM;
            else move_to_table(s, n);
          end
        end
        REQ_APPEND: begin
          if (!held[s]) o.status = ST_NOTFOUND;
          else if (cnt < r.logical_cnt) begin
            if (tbl_len[s] >= MAX_BLOCKS_PER_SEQ) o.status = ST_FULL;
            else if (stack_top == 0) o.status = ST_OOM;
            else begin
              move_to_table(s, 1);
              o.blk_id = tbl_ids[s][tbl_len[s] - 1];
              o.appended = 1;
              appends++;
            end
          end
        end
        REQ_FREE: begin
          if (held[s]) begin
            for (int i = 0; i < tbl_len[s]; i++)
              if (stack_top < POOL_SIZE) begin
                stack_ids[stack_top] = tbl_ids[s][i];
                stack_top++;
              end
            held[s] = 0;
            tbl_len[s] = 0;
          end
        end
        REQ_READ: begin
          if (!held[s]) o.status = ST_NOTFOUND;
          else if (r.entry_index >= tbl_len[s]) o.status = ST_BADIDX;
          else o.blk_id = tbl_ids[s][r.entry_index];
        end
        REQ_INIT: begin
          n = total_cfg > POOL_SIZE ? POOL_SIZE : total_cfg;
          for (int i = 0; i < n; i++) stack_ids[i] = 10'(i);
          stack_top = n;
          foreach (held[i]) begin
            held[i] = 0;
            tbl_len[i] = 0;
          end
        end
        default: ;  // query, and the unused code behaves as query
      endcase
      if (o.status == ST_OOM) ooms++;
      o.can_allocate = stack_top >= cnt + wmark_cfg;
      o.is_allocated = held[s];
      o.free_count = 11'(stack_top);
      o.table_length = held[s] ? 7'(tbl_len[s]) : 7'd0;
      pending = {pending, o};
    endfunction

    function void check(pba_out_t got);
      pba_out_t e;
      results++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.blk_id != e.blk_id) begin
        $error("blk_id: expected %0d, got %0d", e.blk_id, got.blk_id);
        errors++;
      end
      if (got.appended != e.appended) begin
        $error("appended: expected %0d, got %0d", e.appended, got.appended);
        errors++;
      end
      if (got.can_allocate != e.can_allocate) begin
        $error("can_allocate: expected %0d, got %0d", e.can_allocate, got.can_allocate);
        errors++;
      end
      if (got.is_allocated != e.is_allocated) begin
        $error("is_allocated: expected %0d, got %0d", e.is_allocated, got.is_allocated);
        errors++;
      end
      if (got.free_count != e.free_count) begin
        $error("free_count: expected %0d, got %0d", e.free_count, got.free_count);
        errors++;
      end
      if (got.table_length != e.table_length) begin
        $error("table_length: expected %0d, got %0d", e.table_length, got.table_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pba_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pba_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [10:0] cfg_data;

  alloc_scoreboard sb;
  bit quiet;
  int idle_cycles;
  int sent;

  paged_block_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial sb = new();

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note(in_data);
      if (out_valid && !out_stall) sb.check(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result-side backpressure in random bursts
  initial begin
    int k;
    out_stall = 0;
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 0;
        k = $urandom_range(1, 30);
      end else begin
        out_stall <= 1;
        k = $urandom_range(1, 19);
      end
      repeat (k) @(posedge clk);
    end
  end

  task automatic send(logic [2:0] rq, int s, int cnt, int lg, int idx);
    pba_in_t r;
    int gap;
    r.req_type = rq;
    r.seq_slot = 6'(s);
    r.block_count = 7'(cnt);
    r.logical_cnt = 7'(lg);
    r.entry_index = 6'(idx);
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes both registers back to back, block must be idle
  task automatic set_regs(int total, int wmark);
    cfg_valid <= 1;
    cfg_index <= CFG_TOTAL;
    cfg_data <= 11'(total);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_WMARK;
    cfg_data <= 11'(wmark);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int p, s, cnt;
    logic [2:0] rq;
    p = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
    if (p < 18) rq = REQ_ALLOC;
    else if (p < 32) rq = REQ_GROW;
    else if (p < 52) rq = REQ_APPEND;
    else if (p < 66) rq = REQ_FREE;
    else if (p < 86) rq = REQ_READ;
    else if (p < 98) rq = ($urandom_range(0, 1) == 0) ? REQ_QUERY : REQ_RSVD;
    else rq = REQ_INIT;
    if (rq == REQ_GROW && s < MAX_SEQS && sb.held[s]) cnt = sb.tbl_len[s] + $urandom_range(0, 4);
    if (rq == REQ_APPEND && s < MAX_SEQS && $urandom_range(0, 3) != 0)
      send(rq, s, sb.tbl_len[s], sb.tbl_len[s] + $urandom_range(0, 1), $urandom_range(0, 63));
    else if (rq == REQ_READ && s < MAX_SEQS && sb.tbl_len[s] > 0 && $urandom_range(0, 3) != 0)
      send(rq, s, cnt, $urandom_range(0, 127), $urandom_range(0, sb.tbl_len[s] - 1));
    else
      send(rq, s, cnt, $urandom_range(0, 127), $urandom_range(0, 63));
  endtask

  initial begin
    int phase_total, phase_wmark, sel;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = CFG_TOTAL;
    cfg_data = '0;
    quiet = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: edges of every request type
    send(REQ_QUERY, 0, 127, 127, 63);
    send(REQ_INIT, 63, 0, 0, 0);
    send(REQ_ALLOC, 0, 64, 0, 0);
    send(REQ_ALLOC, 0, 1, 0, 0);
    send(REQ_ALLOC, 1, 65, 0, 0);
    send(REQ_ALLOC, 1, 0, 0, 0);
    send(REQ_GROW, 1, 3, 0, 0);
    send(REQ_GROW, 1, 2, 0, 0);
    send(REQ_GROW, 1, 100, 0, 0);
    send(REQ_GROW, 63, 5, 0, 0);
    send(REQ_APPEND, 5, 0, 1, 0);
    send(REQ_APPEND, 1, 3, 4, 0);
    send(REQ_APPEND, 1, 4, 4, 0);
    send(REQ_APPEND, 0, 0, 127, 0);
    send(REQ_READ, 0, 0, 0, 63);
    send(REQ_READ, 1, 0, 0, 63);
    send(REQ_READ, 9, 0, 0, 0);
    send(REQ_FREE, 0, 0, 0, 0);
    send(REQ_FREE, 0, 0, 0, 0);
    send(REQ_RSVD, 63, 64, 0, 0);
    drain();
    set_regs(2, 1024);
    send(REQ_INIT, 0, 0, 0, 0);
    send(REQ_ALLOC, 3, 3, 0, 0);
    send(REQ_ALLOC, 3, 2, 0, 0);
    send(REQ_APPEND, 3, 0, 1, 0);
    send(REQ_GROW, 3, 3, 0, 0);
    drain();
    set_regs(0, 0);
    send(REQ_INIT, 0, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 0, 0);

    // random phases with a fresh register setting and pool each
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      sel = $urandom_range(0, 3);
      phase_total = (ph == 0) ? 1024 : (sel == 0) ? $urandom_range(0, 1024) :
                    (sel == 1) ? $urandom_range(0, 40) : 1024;
      phase_wmark = (ph == 1) ? 1024 : ($urandom_range(0, 1) == 0) ? 0 :
                    $urandom_range(0, 1024);
      set_regs(phase_total, phase_wmark);
      send(REQ_INIT, $urandom_range(0, 63), 0, 0, 0);
      if (ph == 5) quiet = 1;
      repeat (320) random_request();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d requests over several pool sizes and watermarks; %0d results checked,",
             sent, sb.results);
    $display("%0d appends and %0d out-of-memory rejections seen.", sb.appends, sb.ooms);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/paged_block_allocator.sv
verif/testbench.sv
